[hdl/bpc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package bpc_pkg;

  localparam int TIME_WIDTH      = 32;
  localparam int PORT_WIDTH      = 32;
  localparam int CFG_DATA_WIDTH  = 16;
  localparam int CFG_INDEX_WIDTH = 2;

  localparam logic [CFG_DATA_WIDTH-1:0] PIN_MASK_RESET    = 16'd1;
  localparam logic [CFG_DATA_WIDTH-1:0] DEBOUNCE_MS_RESET = 16'd100;
  localparam logic [CFG_DATA_WIDTH-1:0] LONG_MS_RESET     = 16'd1000;

  typedef enum logic [1:0] {
    PH_IDLE         = 2'd0,
    PH_DEBOUNCE     = 2'd1,
    PH_WAIT_LONG    = 2'd2,
    PH_WAIT_RELEASE = 2'd3
  } phase_t;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    CFG_PIN_MASK    = 2'd0,
    CFG_DEBOUNCE_MS = 2'd1,
    CFG_LONG_MS     = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic [CFG_DATA_WIDTH-1:0] pin_mask;
    logic [CFG_DATA_WIDTH-1:0] debounce_ms;
    logic [CFG_DATA_WIDTH-1:0] long_ms;
  } cfg_t;

  typedef struct packed {
    phase_t                phase;
    logic [TIME_WIDTH-1:0] start_ms;
  } state_t;

  typedef struct packed {
    logic   short_event;
    logic   long_event;
    logic   press_event;
    phase_t phase_out;
  } result_t;

endpackage

`default_nettype wire

[hdl/bpc_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface bpc_in_if;
  import bpc_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [PORT_WIDTH-1:0] port_word;
  logic [31:0]           now_ms;

  modport source (output valid, output port_word, output now_ms, input ready);
  modport sink   (input valid, input port_word, input now_ms, output ready);
endinterface

`default_nettype wire

[hdl/bpc_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface bpc_out_if;
  logic       valid;
  logic       ready;
  logic       short_event;
  logic       long_event;
  logic       press_event;
  logic [1:0] phase_out;

  modport source (output valid, output short_event, output long_event,
                  output press_event, output phase_out, input ready);
  modport sink   (input valid, input short_event, input long_event,
                  input press_event, input phase_out, output ready);
endinterface

`default_nettype wire

[hdl/bpc_cfg_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface bpc_cfg_if;
  import bpc_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [CFG_INDEX_WIDTH-1:0] index;
  logic [CFG_DATA_WIDTH-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[hdl/bpc_cfg_regs.sv]
`timescale 1ns / 1ps
`default_nettype none

module bpc_cfg_regs (
  input  wire logic    clk,
  input  wire logic    rst_n,
  bpc_cfg_if.sink      cfg_chan,
  output bpc_pkg::cfg_t cfg
);
  import bpc_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_chan.ready = 1'b1;
  assign cfg            = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_chan.valid) begin
      case (cfg_chan.index)
        CFG_PIN_MASK:    cfg_nxt.pin_mask    = cfg_chan.data;
        CFG_DEBOUNCE_MS: cfg_nxt.debounce_ms = cfg_chan.data;
        CFG_LONG_MS:     cfg_nxt.long_ms     = cfg_chan.data;
        default:         cfg_nxt             = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pin_mask    <= PIN_MASK_RESET;
      cfg_r.debounce_ms <= DEBOUNCE_MS_RESET;
      cfg_r.long_ms     <= LONG_MS_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

[hdl/bpc_step.sv]
`timescale 1ns / 1ps
`default_nettype none

module bpc_step (
  input  wire logic [31:0]   port_word,
  input  wire logic [31:0]   now_ms,
  input  wire bpc_pkg::cfg_t cfg,
  input  wire bpc_pkg::state_t cur,
  output bpc_pkg::state_t    nxt,
  output bpc_pkg::result_t   res
);
  import bpc_pkg::*;

  logic                  pressed;
  logic [TIME_WIDTH-1:0] now_t;
  logic [TIME_WIDTH-1:0] elapsed;
  logic                  debounced;
  logic                  held_long;
  logic                  sev;
  logic                  lev;

  assign pressed   = (port_word & PORT_WIDTH'(cfg.pin_mask)) == '0;
  assign now_t     = TIME_WIDTH'(now_ms);
  assign elapsed   = now_t - cur.start_ms;
  assign debounced = elapsed >= TIME_WIDTH'(cfg.debounce_ms);
  assign held_long = elapsed >= TIME_WIDTH'(cfg.long_ms);

  always_comb begin
    nxt = cur;
    sev = 1'b0;
    lev = 1'b0;
    case (cur.phase)
      PH_IDLE: begin
        if (pressed) begin
          nxt.phase    = PH_DEBOUNCE;
          nxt.start_ms = now_t;
        end
      end
      PH_DEBOUNCE: begin
        if (pressed && debounced) begin
          nxt.phase    = PH_WAIT_LONG;
          nxt.start_ms = now_t;
        end
      end
      PH_WAIT_LONG: begin
        if (!pressed) begin
          sev       = 1'b1;
          nxt.phase = PH_IDLE;
        end else if (held_long) begin
          lev          = 1'b1;
          nxt.phase    = PH_WAIT_RELEASE;
          nxt.start_ms = '0;
        end
      end
      PH_WAIT_RELEASE: begin
        if (!pressed) begin
          nxt.phase = PH_IDLE;
        end
      end
      default: nxt = cur;
    endcase
  end

  always_comb begin
    res.short_event = sev;
    res.long_event  = lev;
    res.press_event = sev | lev;
    res.phase_out   = nxt.phase;
  end

endmodule

`default_nettype wire

[hdl/button_press_classifier_unit.sv]
// Button press classifier: each input beat is one poll (port word and millisecond count)
// and gives exactly one result beat in the next cycle, carrying the short, long and press
// events and the phase after that poll. A poll is taken every cycle while the result
// register is empty or being drained in the same cycle, so the sustained rate is one poll
// per cycle; it is set by the phase and start-time register, which is updated once per
// accepted poll. Configuration writes are taken every cycle and act from the next poll.
`timescale 1ns / 1ps
`default_nettype none

module button_press_classifier_unit (
  input  wire logic clk,
  input  wire logic rst_n,
  bpc_in_if.sink    in_chan,
  bpc_out_if.source out_chan,
  bpc_cfg_if.sink   cfg_chan
);
  import bpc_pkg::*;

  cfg_t    cfg;
  state_t  state_r;
  state_t  state_nxt;
  result_t res_nxt;
  result_t res_r;
  logic    out_valid_r;
  logic    out_valid_nxt;
  logic    in_fire;

  bpc_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_chan),
    .cfg      (cfg)
  );

  bpc_step u_step (
    .port_word (in_chan.port_word),
    .now_ms    (in_chan.now_ms),
    .cfg       (cfg),
    .cur       (state_r),
    .nxt       (state_nxt),
    .res       (res_nxt)
  );

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign in_fire       = in_chan.valid && in_chan.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase    <= PH_IDLE;
      state_r.start_ms <= '0;
      out_valid_r      <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_fire) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.short_event = res_r.short_event;
  assign out_chan.long_event  = res_r.long_event;
  assign out_chan.press_event = res_r.press_event;
  assign out_chan.phase_out   = res_r.phase_out;

  a_fire_gives_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted poll did not produce a result beat");

  a_long_to_release: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.long_event) |-> (res_r.phase_out == PH_WAIT_RELEASE))
    else $error("long event without wait-release phase");

  a_short_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.short_event) |-> (res_r.phase_out == PH_IDLE && !res_r.long_event))
    else $error("short event without return to idle");

  a_release_start_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.phase == PH_WAIT_RELEASE) |-> (state_r.start_ms == '0))
    else $error("start time not cleared in wait-release");

  a_phase_tracks_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (res_r.phase_out == state_r.phase))
    else $error("result phase differs from held phase");

endmodule

`default_nettype wire

[test/tb_button_press_classifier_unit.sv]
`timescale 1ns / 1ps

module tb_button_press_classifier_unit;
  import bpc_pkg::*;

  localparam int TOTAL_POLLS = 1150;
  localparam int CYCLE_LIMIT = 250000;
  localparam int SETTLE_CYCLES = 3;

  class press_checker;
    logic [CFG_DATA_WIDTH-1:0] pin_mask;
    logic [CFG_DATA_WIDTH-1:0] debounce_ms;
    logic [CFG_DATA_WIDTH-1:0] long_ms;
    phase_t                    phase;
    logic [TIME_WIDTH-1:0]     start_ms;
    result_t                   expected_results[$];
    int unsigned               errors;

    function new();
      pin_mask    = PIN_MASK_RESET;
      debounce_ms = DEBOUNCE_MS_RESET;
      long_ms     = LONG_MS_RESET;
      phase       = PH_IDLE;
      start_ms    = '0;
      errors      = 0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void write_reg(cfg_index_t idx, logic [CFG_DATA_WIDTH-1:0] value);
      case (idx)
        CFG_PIN_MASK:    pin_mask = value;
        CFG_DEBOUNCE_MS: debounce_ms = value;
        CFG_LONG_MS:     long_ms = value;
        default: ;
      endcase
    endfunction

    // note an accepted poll and queue the result it must produce
    function void note_poll(logic [PORT_WIDTH-1:0] port, logic [31:0] now);
      logic                  pressed;
      logic [TIME_WIDTH-1:0] elapsed;
      result_t               res;
      pressed = (port & {{(PORT_WIDTH - CFG_DATA_WIDTH){1'b0}}, pin_mask}) == '0;
      elapsed = now - start_ms;
      res = '0;
      if (pressed && phase == PH_IDLE) begin
        phase    = PH_DEBOUNCE;
        start_ms = now;
      end else if (phase != PH_IDLE) begin
        if (pressed && phase == PH_DEBOUNCE && elapsed >= debounce_ms) begin
          phase    = PH_WAIT_LONG;
          start_ms = now;
        end else if (!pressed && phase == PH_WAIT_LONG) begin
          res.short_event = 1'b1;
          phase           = PH_IDLE;
        end else if (pressed && phase == PH_WAIT_LONG && elapsed >= long_ms) begin
          res.long_event = 1'b1;
          phase          = PH_WAIT_RELEASE;
          start_ms       = '0;
        end
      end
      if (phase == PH_WAIT_RELEASE && !pressed)
        phase = PH_IDLE;
      res.press_event = res.short_event | res.long_event;
      res.phase_out   = phase;
      expected_results.push_back(res);
    endfunction

    function void compare_field(string name, int exp_val, int act_val);
      if (exp_val != act_val) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val,
                 act_val);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t exp_res;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual %0d/%0d/%0d/%0d",
                 $time, got.short_event, got.long_event, got.press_event, got.phase_out);
        errors++;
        return;
      end
      exp_res = expected_results.pop_front();
      compare_field("short_event", exp_res.short_event, got.short_event);
      compare_field("long_event", exp_res.long_event, got.long_event);
      compare_field("press_event", exp_res.press_event, got.press_event);
      compare_field("phase_out", exp_res.phase_out, got.phase_out);
    endfunction
  endclass

  logic clk;
  logic rst_n;

  bpc_in_if  in_if();
  bpc_out_if out_if();
  bpc_cfg_if cfg_if();

  button_press_classifier_unit uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  press_checker              chk;
  int unsigned               cycle_count;
  int unsigned               sent;
  int unsigned               hold_off_cycles;
  int unsigned               step_max;
  bit                        tx_gap_on;
  bit                        rx_stall_on;
  logic [CFG_DATA_WIDTH-1:0] cur_mask;
  logic [31:0]               clock_ms;

  initial begin
    clk = 1'b0;
  end

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    result_t got;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        got.short_event = out_if.short_event;
        got.long_event  = out_if.long_event;
        got.press_event = out_if.press_event;
        got.phase_out   = phase_t'(out_if.phase_out);
        chk.check_result(got);
      end
      if (in_if.valid && in_if.ready)
        chk.note_poll(in_if.port_word, in_if.now_ms);
      if (cfg_if.valid && cfg_if.ready)
        chk.write_reg(cfg_index_t'(cfg_if.index), cfg_if.data);
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    out_if.ready = 1'b0;
    forever begin
      if (hold_off_cycles > 0) begin
        out_if.ready <= 1'b0;
        repeat (hold_off_cycles) @(posedge clk);
        hold_off_cycles = 0;
      end else if (rx_stall_on && $urandom_range(0, 4) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        out_if.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_poll(logic [PORT_WIDTH-1:0] port, logic [31:0] now);
    if (tx_gap_on && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.port_word <= port;
    in_if.now_ms    <= now;
    do @(posedge clk); while (!in_if.ready);
    sent++;
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (chk.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_WIDTH-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
  endtask

  task automatic apply_config(logic [CFG_DATA_WIDTH-1:0] mask,
                              logic [CFG_DATA_WIDTH-1:0] deb,
                              logic [CFG_DATA_WIDTH-1:0] lng);
    drain();
    write_reg(CFG_PIN_MASK, mask);
    write_reg(CFG_DEBOUNCE_MS, deb);
    write_reg(CFG_LONG_MS, lng);
    cfg_if.valid <= 1'b0;
    cur_mask = mask;
    step_max = (int'(deb) + int'(lng)) / 3 + 2;
  endtask

  function automatic logic [PORT_WIDTH-1:0] press_word();
    return $urandom & ~{{(PORT_WIDTH - CFG_DATA_WIDTH){1'b0}}, cur_mask};
  endfunction

  function automatic logic [PORT_WIDTH-1:0] release_word();
    logic [PORT_WIDTH-1:0] w;
    int unsigned           k;
    w = $urandom;
    if (cur_mask != '0) begin
      do k = $urandom_range(0, CFG_DATA_WIDTH - 1); while (!cur_mask[k]);
      w[k] = 1'b1;
    end
    return w;
  endfunction

  function automatic logic [31:0] time_step();
    if ($urandom_range(0, 19) == 0)
      return $urandom;
    return $urandom_range(0, step_max);
  endfunction

  // hold with occasional bounce, then release
  task automatic press_run();
    int unsigned hold_polls;
    int unsigned rel_polls;
    hold_polls = $urandom_range(1, 12);
    rel_polls  = $urandom_range(1, 3);
    repeat (hold_polls) begin
      clock_ms += time_step();
      if ($urandom_range(0, 7) == 0)
        send_poll(release_word(), clock_ms);
      else
        send_poll(press_word(), clock_ms);
    end
    repeat (rel_polls) begin
      clock_ms += time_step();
      send_poll(release_word(), clock_ms);
    end
  endtask

  function automatic logic [CFG_DATA_WIDTH-1:0] pick_mask();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return CFG_DATA_WIDTH'($urandom);
      default: return 16'h0001 << $urandom_range(0, CFG_DATA_WIDTH - 1);
    endcase
  endfunction

  initial begin
    int unsigned               phase_no;
    int unsigned               phase_end;
    logic [CFG_DATA_WIDTH-1:0] deb;
    logic [CFG_DATA_WIDTH-1:0] lng;
    bit                        pressure;

    chk             = new();
    rst_n           = 1'b0;
    in_if.valid     = 1'b0;
    in_if.port_word = '0;
    in_if.now_ms    = '0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = CFG_PIN_MASK;
    cfg_if.data     = '0;
    cycle_count     = 0;
    sent            = 0;
    hold_off_cycles = 0;
    tx_gap_on       = 1'b0;
    rx_stall_on     = 1'b0;
    cur_mask        = PIN_MASK_RESET;
    step_max        = (int'(DEBOUNCE_MS_RESET) + int'(LONG_MS_RESET)) / 3 + 2;
    clock_ms        = '0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset thresholds: bounce in debounce, short, long, release
    send_poll(32'hFFFF_FFFF, 32'd0);
    send_poll(32'hFFFF_FFFE, 32'd10);
    send_poll(32'h0000_0001, 32'd50);
    send_poll(32'hFFFF_FFFE, 32'd100);
    send_poll(32'hFFFF_FFFE, 32'd110);
    send_poll(32'hFFFF_FFFF, 32'd200);
    send_poll(32'h0000_0000, 32'd300);
    send_poll(32'h0000_0000, 32'd400);
    send_poll(32'h0000_0000, 32'd1400);
    send_poll(32'h0000_0000, 32'd1500);
    send_poll(32'h0000_0001, 32'd1600);
    // counter wrap and a count running backwards
    send_poll(32'h0000_0000, 32'hFFFF_FFF0);
    send_poll(32'h0000_0000, 32'h0000_0054);
    send_poll(32'h0000_0000, 32'h0000_0050);
    send_poll(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // zero mask and zero thresholds
    apply_config('0, '0, '0);
    send_poll(32'hFFFF_FFFF, 32'd0);
    send_poll(32'hFFFF_FFFF, 32'd0);
    send_poll(32'hFFFF_FFFF, 32'd0);
    send_poll(32'hFFFF_FFFF, 32'd0);
    // full mask and largest thresholds
    apply_config('1, '1, '1);
    send_poll(32'h0000_FFFF, 32'd1);
    send_poll(32'hFFFF_0000, 32'd5);
    send_poll(32'hFFFF_0000, 32'd65539);
    send_poll(32'hFFFF_0000, 32'd65540);
    send_poll(32'h0000_8000, 32'd65541);

    phase_no = 0;
    while (sent < TOTAL_POLLS) begin
      phase_no++;
      pressure = (phase_no == 4);
      case (phase_no)
        1: begin
          deb = DEBOUNCE_MS_RESET;
          lng = LONG_MS_RESET;
        end
        2: begin
          deb = '0;
          lng = '0;
        end
        3: begin
          deb = '1;
          lng = '1;
        end
        default: begin
          deb = CFG_DATA_WIDTH'($urandom_range(0, 40));
          lng = CFG_DATA_WIDTH'($urandom_range(0, 150));
        end
      endcase
      apply_config(pick_mask(), deb, lng);
      if (sent + 150 > TOTAL_POLLS) begin
        tx_gap_on   = 1'b0;
        rx_stall_on = 1'b0;
      end else begin
        tx_gap_on   = $urandom_range(0, 3) != 0;
        rx_stall_on = $urandom_range(0, 3) != 0;
      end
      if (pressure) begin
        tx_gap_on       = 1'b0;
        hold_off_cycles = 80;
      end
      if ($urandom_range(0, 3) == 0)
        clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 2000);
      phase_end = sent + 90;
      while (sent < phase_end && sent < TOTAL_POLLS) begin
        if ($urandom_range(0, 9) == 0)
          send_poll($urandom, $urandom);
        else
          press_run();
      end
    end

    drain();
    if (chk.errors == 0 && chk.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
